[rtl/core/iqgsd_pkg.sv]
// Shared constants, codes and types of the IQ grid state discriminator.
package iqgsd_pkg;

	localparam int NUM_QUBITS = 8;
	localparam int GRID_COLS  = 32;
	localparam int GRID_ROWS  = 32;
	localparam int CELLS      = NUM_QUBITS * GRID_ROWS * GRID_COLS;

	localparam int QB_W   = (NUM_QUBITS > 1) ? $clog2(NUM_QUBITS) : 1;
	localparam int COL_W  = $clog2(GRID_COLS);
	localparam int ROW_W  = $clog2(GRID_ROWS);
	localparam int ADDR_W = $clog2(CELLS);

	// fixed field widths of the word formats
	localparam int OP_FW   = 2;
	localparam int QB_FW   = 3;
	localparam int CELL_FW = 5;
	localparam int DATA_W  = 16;

	localparam logic [OP_FW-1:0] OP_CLASSIFY = 2'd0;
	localparam logic [OP_FW-1:0] OP_SCALER   = 2'd1;
	localparam logic [OP_FW-1:0] OP_CELL     = 2'd2;

	typedef struct packed {
		logic [OP_FW-1:0]          operation;
		logic [QB_FW-1:0]          qubit;
		logic signed [DATA_W-1:0]  i_value;
		logic signed [DATA_W-1:0]  q_value;
		logic [CELL_FW-1:0]        cell_column;
		logic [CELL_FW-1:0]        cell_row;
		logic signed [DATA_W-1:0]  density_zero;
		logic signed [DATA_W-1:0]  density_one;
		logic signed [DATA_W-1:0]  offset_i;
		logic signed [DATA_W-1:0]  offset_q;
		logic [DATA_W-1:0]         scale_i;
		logic [DATA_W-1:0]         scale_q;
	} in_word_t;

	// stage advance strobes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic so;
	} stage_en_t;

	// request from the index path to the density tables
	typedef struct packed {
		logic                      rd;
		logic                      wr;
		logic [ADDR_W-1:0]         addr;
		logic [COL_W-1:0]          x;
		logic [ROW_W-1:0]          y;
		logic                      clip;
		logic signed [DATA_W-1:0]  d0;
		logic signed [DATA_W-1:0]  d1;
	} lk_req_t;

	typedef struct packed {
		logic                outcome;
		logic [DATA_W-1:0]   weight;
		logic [CELL_FW-1:0]  column_used;
		logic [CELL_FW-1:0]  row_used;
		logic                clipped;
	} res_t;

endpackage

[rtl/core/iqgsd_in_if.sv]
// Input channel: request word with valid/ready.
interface iqgsd_in_if;
	logic                                    valid;
	logic                                    ready;
	logic [iqgsd_pkg::OP_FW-1:0]             operation;
	logic [iqgsd_pkg::QB_FW-1:0]             qubit;
	logic signed [iqgsd_pkg::DATA_W-1:0]     i_value;
	logic signed [iqgsd_pkg::DATA_W-1:0]     q_value;
	logic [iqgsd_pkg::CELL_FW-1:0]           cell_column;
	logic [iqgsd_pkg::CELL_FW-1:0]           cell_row;
	logic signed [iqgsd_pkg::DATA_W-1:0]     density_zero;
	logic signed [iqgsd_pkg::DATA_W-1:0]     density_one;
	logic signed [iqgsd_pkg::DATA_W-1:0]     offset_i;
	logic signed [iqgsd_pkg::DATA_W-1:0]     offset_q;
	logic [iqgsd_pkg::DATA_W-1:0]            scale_i;
	logic [iqgsd_pkg::DATA_W-1:0]            scale_q;

	modport source (
		output valid, operation, qubit, i_value, q_value, cell_column, cell_row,
			density_zero, density_one, offset_i, offset_q, scale_i, scale_q,
		input ready
	);
	modport sink (
		input valid, operation, qubit, i_value, q_value, cell_column, cell_row,
			density_zero, density_one, offset_i, offset_q, scale_i, scale_q,
		output ready
	);
endinterface

[rtl/core/iqgsd_out_if.sv]
// Output channel: result word with valid/ready.
interface iqgsd_out_if;
	logic                              valid;
	logic                              ready;
	logic                              outcome;
	logic [iqgsd_pkg::DATA_W-1:0]      weight;
	logic [iqgsd_pkg::CELL_FW-1:0]     column_used;
	logic [iqgsd_pkg::CELL_FW-1:0]     row_used;
	logic                              clipped;

	modport source (
		output valid, outcome, weight, column_used, row_used, clipped,
		input ready
	);
	modport sink (
		input valid, outcome, weight, column_used, row_used, clipped,
		output ready
	);
endinterface

[rtl/core/iqgsd_index.sv]
// Scaler store, offset subtract, scale multiply, round/clamp and table address.
module iqgsd_index (
	input  logic                  clk,
	input  iqgsd_pkg::stage_en_t  en,
	input  logic                  acc,
	input  iqgsd_pkg::in_word_t   word,
	output iqgsd_pkg::lk_req_t    lk
);

	typedef struct packed {
		logic        clip;
		logic [24:0] idx;
	} axis_t;

	function automatic axis_t axis_index(input logic signed [32:0] p,
			input logic [24:0] top_idx);
		logic [32:0] r;
		axis_t       a;
		r = p + 33'sd128;
		a.clip = 1'b0;
		a.idx  = r[32:8];
		if (p < -33'sd127) begin
			a.clip = 1'b1;
			a.idx  = '0;
		end else if (p[32]) begin
			// small negative rounds to cell zero without clamping
			a.idx = '0;
		end else if (r[32:8] > top_idx) begin
			a.clip = 1'b1;
			a.idx  = top_idx;
		end
		return a;
	endfunction

	logic signed [iqgsd_pkg::DATA_W-1:0] offset_i_mem [iqgsd_pkg::NUM_QUBITS];
	logic signed [iqgsd_pkg::DATA_W-1:0] offset_q_mem [iqgsd_pkg::NUM_QUBITS];
	logic [iqgsd_pkg::DATA_W-1:0]        scale_i_mem  [iqgsd_pkg::NUM_QUBITS];
	logic [iqgsd_pkg::DATA_W-1:0]        scale_q_mem  [iqgsd_pkg::NUM_QUBITS];

	logic [iqgsd_pkg::QB_W-1:0] qb_idx;
	logic                       act_in;

	// stage 1
	logic [iqgsd_pkg::OP_FW-1:0]         op_s1;
	logic                                act_s1;
	logic [iqgsd_pkg::QB_FW-1:0]         qb_s1;
	logic [iqgsd_pkg::CELL_FW-1:0]       col_s1, row_s1;
	logic signed [iqgsd_pkg::DATA_W-1:0] d0_s1, d1_s1;
	logic signed [iqgsd_pkg::DATA_W:0]   dfi_s1, dfq_s1;
	logic [iqgsd_pkg::DATA_W-1:0]        sci_s1, scq_s1;

	// stage 2
	logic [iqgsd_pkg::OP_FW-1:0]         op_s2;
	logic                                act_s2;
	logic [iqgsd_pkg::QB_FW-1:0]         qb_s2;
	logic [iqgsd_pkg::CELL_FW-1:0]       col_s2, row_s2;
	logic signed [iqgsd_pkg::DATA_W-1:0] d0_s2, d1_s2;
	logic signed [32:0]                  pi_s2, pq_s2;
	logic signed [33:0]                  mul_i, mul_q;

	axis_t                               ax_i, ax_q;
	logic                                cell_ok;
	logic [iqgsd_pkg::ADDR_W-1:0]        cls_addr, cell_addr;
	iqgsd_pkg::lk_req_t                  lk_next;
	iqgsd_pkg::lk_req_t                  lk_s3;

	assign qb_idx = iqgsd_pkg::QB_W'(word.qubit);
	assign act_in = int'(word.qubit) < iqgsd_pkg::NUM_QUBITS;

	always_ff @(posedge clk) begin
		if (acc && act_in && word.operation == iqgsd_pkg::OP_SCALER) begin
			offset_i_mem[qb_idx] <= word.offset_i;
			offset_q_mem[qb_idx] <= word.offset_q;
			scale_i_mem[qb_idx]  <= word.scale_i;
			scale_q_mem[qb_idx]  <= word.scale_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1  <= word.operation;
			act_s1 <= act_in;
			qb_s1  <= word.qubit;
			col_s1 <= word.cell_column;
			row_s1 <= word.cell_row;
			d0_s1  <= word.density_zero;
			d1_s1  <= word.density_one;
			dfi_s1 <= {word.i_value[iqgsd_pkg::DATA_W-1], word.i_value}
				- {offset_i_mem[qb_idx][iqgsd_pkg::DATA_W-1], offset_i_mem[qb_idx]};
			dfq_s1 <= {word.q_value[iqgsd_pkg::DATA_W-1], word.q_value}
				- {offset_q_mem[qb_idx][iqgsd_pkg::DATA_W-1], offset_q_mem[qb_idx]};
			sci_s1 <= scale_i_mem[qb_idx];
			scq_s1 <= scale_q_mem[qb_idx];
		end
	end

	assign mul_i = 34'(dfi_s1) * 34'($signed({1'b0, sci_s1}));
	assign mul_q = 34'(dfq_s1) * 34'($signed({1'b0, scq_s1}));

	always_ff @(posedge clk) begin
		if (en.s2) begin
			op_s2  <= op_s1;
			act_s2 <= act_s1;
			qb_s2  <= qb_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			d0_s2  <= d0_s1;
			d1_s2  <= d1_s1;
			pi_s2  <= mul_i[32:0];
			pq_s2  <= mul_q[32:0];
		end
	end

	always_comb begin
		ax_i = axis_index(pi_s2, 25'(iqgsd_pkg::GRID_COLS - 1));
		ax_q = axis_index(pq_s2, 25'(iqgsd_pkg::GRID_ROWS - 1));
		cell_ok = (int'(col_s2) < iqgsd_pkg::GRID_COLS)
			&& (int'(row_s2) < iqgsd_pkg::GRID_ROWS);
		cls_addr = iqgsd_pkg::ADDR_W'((int'(qb_s2) * iqgsd_pkg::GRID_ROWS
			+ int'(ax_q.idx[iqgsd_pkg::ROW_W-1:0])) * iqgsd_pkg::GRID_COLS
			+ int'(ax_i.idx[iqgsd_pkg::COL_W-1:0]));
		cell_addr = iqgsd_pkg::ADDR_W'((int'(qb_s2) * iqgsd_pkg::GRID_ROWS
			+ int'(row_s2)) * iqgsd_pkg::GRID_COLS + int'(col_s2));
		lk_next.rd   = act_s2 && op_s2 == iqgsd_pkg::OP_CLASSIFY;
		lk_next.wr   = act_s2 && op_s2 == iqgsd_pkg::OP_CELL && cell_ok;
		lk_next.addr = (op_s2 == iqgsd_pkg::OP_CELL) ? cell_addr : cls_addr;
		lk_next.x    = ax_i.idx[iqgsd_pkg::COL_W-1:0];
		lk_next.y    = ax_q.idx[iqgsd_pkg::ROW_W-1:0];
		lk_next.clip = ax_i.clip || ax_q.clip;
		lk_next.d0   = d0_s2;
		lk_next.d1   = d1_s2;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			lk_s3 <= lk_next;
		end
	end

	assign lk = lk_s3;

endmodule

[rtl/core/iqgsd_lookup.sv]
// Density tables (one write or read per cycle) and the compare/result stage.
module iqgsd_lookup (
	input  logic                  clk,
	input  iqgsd_pkg::stage_en_t  en,
	input  logic                  v3,
	input  iqgsd_pkg::lk_req_t    lk,
	output iqgsd_pkg::res_t       res
);

	logic signed [iqgsd_pkg::DATA_W-1:0] zero_mem [iqgsd_pkg::CELLS];
	logic signed [iqgsd_pkg::DATA_W-1:0] one_mem  [iqgsd_pkg::CELLS];

	logic                                we, re;
	logic signed [iqgsd_pkg::DATA_W-1:0] rd0_s4, rd1_s4;
	logic                                cls_s4;
	logic [iqgsd_pkg::COL_W-1:0]         x_s4;
	logic [iqgsd_pkg::ROW_W-1:0]         y_s4;
	logic                                clip_s4;
	logic signed [iqgsd_pkg::DATA_W:0]   diff;
	logic                                zero_wins;
	iqgsd_pkg::res_t                     res_next;
	iqgsd_pkg::res_t                     res_q;

	assign we = en.s4 && v3 && lk.wr;
	assign re = en.s4 && v3 && lk.rd;

	always_ff @(posedge clk) begin
		if (we) begin
			zero_mem[lk.addr] <= lk.d0;
		end
		if (re) begin
			rd0_s4 <= zero_mem[lk.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			one_mem[lk.addr] <= lk.d1;
		end
		if (re) begin
			rd1_s4 <= one_mem[lk.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			cls_s4  <= lk.rd;
			x_s4    <= lk.x;
			y_s4    <= lk.y;
			clip_s4 <= lk.clip;
		end
	end

	always_comb begin
		zero_wins = rd0_s4 > rd1_s4;
		diff = zero_wins
			? {rd0_s4[iqgsd_pkg::DATA_W-1], rd0_s4} - {rd1_s4[iqgsd_pkg::DATA_W-1], rd1_s4}
			: {rd1_s4[iqgsd_pkg::DATA_W-1], rd1_s4} - {rd0_s4[iqgsd_pkg::DATA_W-1], rd0_s4};
		res_next = '0;
		if (cls_s4) begin
			res_next.outcome     = !zero_wins;
			res_next.weight      = diff[iqgsd_pkg::DATA_W-1:0];
			res_next.column_used = iqgsd_pkg::CELL_FW'(x_s4);
			res_next.row_used    = iqgsd_pkg::CELL_FW'(y_s4);
			res_next.clipped     = clip_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en.so) begin
			res_q <= res_next;
		end
	end

	assign res = res_q;

endmodule

[rtl/core/iq_grid_state_discriminator.sv]
// Top level of the IQ grid state discriminator: stage control and channel wiring.
//
//   channel  dir  word
//   req      in   operation, qubit, sample, cell, densities, scaler entry
//   rsp      out  outcome, weight, column_used, row_used, clipped
//
// One word in per cycle while req is ready, one result per word; rsp.valid comes from the
// output stage. The pipeline runs subtract, multiply, round/clamp, table read, compare;
// the density tables take one access per cycle, reads and writes kept in word order.
// Each stage advances when the next one is empty or moving, so bubbles close up and
// req stays ready while a result waits on rsp until the four stages behind it fill.
// arst_n clears the stage valids only; the stores hold no value until written.
module iq_grid_state_discriminator (
	input  logic           clk,
	input  logic           arst_n,
	iqgsd_in_if.sink       req,
	iqgsd_out_if.source    rsp
);

	logic                 v1_q, v2_q, v3_q, v4_q, vo_q;
	iqgsd_pkg::stage_en_t en;
	iqgsd_pkg::in_word_t  word;
	iqgsd_pkg::lk_req_t   lk;
	iqgsd_pkg::res_t      res;
	logic                 acc;

	always_comb begin
		en.so = !vo_q || rsp.ready;
		en.s4 = !v4_q || en.so;
		en.s3 = !v3_q || en.s4;
		en.s2 = !v2_q || en.s3;
		en.s1 = !v1_q || en.s2;
	end

	assign req.ready = en.s1;
	assign acc       = req.valid && en.s1;

	always_comb begin
		word.operation    = req.operation;
		word.qubit        = req.qubit;
		word.i_value      = req.i_value;
		word.q_value      = req.q_value;
		word.cell_column  = req.cell_column;
		word.cell_row     = req.cell_row;
		word.density_zero = req.density_zero;
		word.density_one  = req.density_one;
		word.offset_i     = req.offset_i;
		word.offset_q     = req.offset_q;
		word.scale_i      = req.scale_i;
		word.scale_q      = req.scale_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en.s1) v1_q <= req.valid;
			if (en.s2) v2_q <= v1_q;
			if (en.s3) v3_q <= v2_q;
			if (en.s4) v4_q <= v3_q;
			if (en.so) vo_q <= v4_q;
		end
	end

	iqgsd_index u_index (
		.clk    (clk),
		.en     (en),
		.acc    (acc),
		.word   (word),
		.lk     (lk)
	);

	iqgsd_lookup u_lookup (
		.clk    (clk),
		.en     (en),
		.v3     (v3_q),
		.lk     (lk),
		.res    (res)
	);

	assign rsp.valid       = vo_q;
	assign rsp.outcome     = res.outcome;
	assign rsp.weight      = res.weight;
	assign rsp.column_used = res.column_used;
	assign rsp.row_used    = res.row_used;
	assign rsp.clipped     = res.clipped;

endmodule
